// ===== src/fta_pkg.sv =====
package fta_pkg;

   localparam int FRAME_COUNT_DEF = 64;
   localparam int OWNER_BITS      = 16;
   localparam int PAGE_BITS       = 20;
   localparam int FRAME_BITS      = 8;
   localparam int STATUS_BITS     = 3;
   localparam int OCC_BITS        = 7;
   localparam int OPS_BITS        = 32;

   localparam logic [1:0] REQ_ALLOC    = 2'd0;
   localparam logic [1:0] REQ_RELEASE  = 2'd1;
   localparam logic [1:0] REQ_REASSIGN = 2'd2;
   localparam logic [1:0] REQ_CHECK    = 2'd3;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_BAD_FRAME = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NONE_OCC  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_DUPLICATE = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_ALLOC = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_CMP,
      ST_DONE
   } fta_state_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [OWNER_BITS-1:0] owner_id;
      logic [PAGE_BITS-1:0]  page_number;
      logic [FRAME_BITS-1:0] frame_number;
   } fta_req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0]  granted_frame;
      logic                   pair_matches;
      logic [STATUS_BITS-1:0] status;
      logic [OCC_BITS-1:0]    occupied_count;
      logic [OPS_BITS-1:0]    operation_count;
   } fta_rsp_type;

endpackage

// ===== src/frame_table_allocator.sv =====
// First-fit frame table with one read port. Allocate scans the table from frame 0, one
// entry per cycle, and stops at the first free frame. Reassign scans the whole table for
// a duplicate pair and stops early only when one turns up. Check reads the addressed
// frame once; release and any out-of-range request go straight to completion. The table
// reads as cleared right after reset through per-frame valid bits, so there is no
// clearing pass. A new request is taken only while the sequencer is idle; the finished
// beat waits in an output register.
module frame_table_allocator #(
   parameter int FRAME_COUNT = fta_pkg::FRAME_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fta_pkg::fta_req_type req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fta_pkg::fta_rsp_type rsp
);
   import fta_pkg::*;

   localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int SW = $clog2(FRAME_COUNT + 1);

   logic [OWNER_BITS-1:0] owner_mem [FRAME_COUNT];
   logic [PAGE_BITS-1:0]  page_mem  [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] valid_ff;

   fta_state_type state_ff, state_in;
   fta_req_type   req_ff, req_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic          self_free_ff, self_free_in;

   logic [FRAME_BITS-1:0]  res_granted_ff, res_granted_in;
   logic                   res_match_ff, res_match_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                   wr_ff, wr_in;
   logic                   clr_ff, clr_in;
   logic [AW-1:0]          wr_addr_ff, wr_addr_in;
   logic                   occ_inc_ff, occ_inc_in;
   logic                   occ_dec_ff, occ_dec_in;
   logic                   ops_inc_ff, ops_inc_in;

   logic [SW-1:0]       occ_ff, occ_in;
   logic [OPS_BITS-1:0] ops_ff, ops_in;

   logic [OWNER_BITS-1:0] rd_owner_ff;
   logic [PAGE_BITS-1:0]  rd_page_ff;
   logic                  rd_ok_ff;
   logic [AW-1:0]         rd_idx_ff;
   logic                  rd_live_ff, rd_live_in;

   fta_rsp_type rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  commit;
   logic                  slot_free;
   logic                  rd_issue;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         req_idx;
   logic                  idx_bad;
   logic [OWNER_BITS-1:0] eff_owner;
   logic [PAGE_BITS-1:0]  eff_page;
   logic                  pair_eq;
   logic                  at_self;
   logic                  self_free_now;
   logic                  alloc_hit;
   logic                  dup_hit;
   logic                  scan_end;
   logic [FRAME_BITS-1:0] occ_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DONE) && slot_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Table read port: scan pointer while scanning, addressed frame otherwise.
   assign rd_issue = ((state_ff == ST_SCAN) && (scan_ff < FRAME_COUNT)) || (state_ff == ST_READ);
   assign rd_addr  = (state_ff == ST_SCAN) ? scan_ff[AW-1:0] : req_ff.frame_number[AW-1:0];
   assign rd_live_in = rd_issue;

   assign req_idx = req.frame_number[AW-1:0];
   assign idx_bad = ({1'b0, req.frame_number} >= (FRAME_BITS + 1)'(FRAME_COUNT));

   // A frame never written since reset reads as zero.
   assign eff_owner     = rd_ok_ff ? rd_owner_ff : '0;
   assign eff_page      = rd_ok_ff ? rd_page_ff : '0;
   assign pair_eq       = (eff_owner == req_ff.owner_id) && (eff_page == req_ff.page_number);
   assign at_self       = (rd_idx_ff == req_ff.frame_number[AW-1:0]);
   assign self_free_now = at_self ? (eff_owner == '0) : self_free_ff;
   assign alloc_hit     = rd_live_ff && (eff_owner == '0);
   assign dup_hit       = rd_live_ff && !at_self && pair_eq;
   assign scan_end      = rd_live_ff && (rd_idx_ff == AW'(FRAME_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.req_type == REQ_ALLOC) begin
                  state_in = ST_SCAN;
               end else if (idx_bad) begin
                  state_in = ST_DONE;
               end else if (req.req_type == REQ_REASSIGN) begin
                  state_in = ST_SCAN;
               end else if (req.req_type == REQ_CHECK) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (req_ff.req_type == REQ_ALLOC) begin
               if (alloc_hit || scan_end) state_in = ST_DONE;
            end else begin
               if (dup_hit || scan_end) state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP:  state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in         = req_ff;
      scan_in        = scan_ff;
      self_free_in   = self_free_ff;
      res_granted_in = res_granted_ff;
      res_match_in   = res_match_ff;
      res_status_in  = res_status_ff;
      wr_in          = wr_ff;
      clr_in         = clr_ff;
      wr_addr_in     = wr_addr_ff;
      occ_inc_in     = occ_inc_ff;
      occ_dec_in     = occ_dec_ff;
      ops_inc_in     = ops_inc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in         = req;
               scan_in        = '0;
               self_free_in   = 1'b0;
               res_granted_in = '0;
               res_match_in   = 1'b0;
               res_status_in  = STAT_OK;
               wr_in          = 1'b0;
               clr_in         = 1'b0;
               wr_addr_in     = req_idx;
               occ_inc_in     = 1'b0;
               occ_dec_in     = 1'b0;
               ops_inc_in     = 1'b0;
               if (req.req_type != REQ_ALLOC && idx_bad) begin
                  res_status_in = STAT_BAD_FRAME;
               end else if (req.req_type == REQ_RELEASE) begin
                  if (occ_ff == '0) begin
                     res_status_in = STAT_NONE_OCC;
                  end else begin
                     occ_dec_in = 1'b1;
                     // an unwritten frame already reads as free
                     clr_in     = valid_ff[req_idx];
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_issue) scan_in = scan_ff + 1'b1;
            if (req_ff.req_type == REQ_ALLOC) begin
               if (alloc_hit) begin
                  res_granted_in = FRAME_BITS'(rd_idx_ff);
                  wr_in          = 1'b1;
                  wr_addr_in     = rd_idx_ff;
                  occ_inc_in     = (occ_ff < FRAME_COUNT);
                  ops_inc_in     = 1'b1;
               end else if (scan_end) begin
                  res_status_in = STAT_FULL;
               end
            end else begin
               self_free_in = self_free_now;
               if (dup_hit) begin
                  res_status_in = STAT_DUPLICATE;
               end else if (scan_end) begin
                  if (self_free_now) begin
                     res_status_in = STAT_NOT_ALLOC;
                  end else begin
                     res_granted_in = req_ff.frame_number;
                     wr_in          = 1'b1;
                     ops_inc_in     = 1'b1;
                  end
               end
            end
         end
         ST_CMP: res_match_in = pair_eq;
         default: ;
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (occ_inc_ff) begin
         occ_in = occ_ff + 1'b1;
      end else if (occ_dec_ff) begin
         occ_in = occ_ff - 1'b1;
      end
   end
   assign ops_in   = ops_inc_ff ? ops_ff + 1'b1 : ops_ff;
   assign occ_wide = FRAME_BITS'(occ_in);

   assign rsp_valid_in = commit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         ops_ff       <= '0;
         valid_ff     <= '0;
         wr_ff        <= 1'b0;
         clr_ff       <= 1'b0;
         occ_inc_ff   <= 1'b0;
         occ_dec_ff   <= 1'b0;
         ops_inc_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
         clr_ff       <= clr_in;
         occ_inc_ff   <= occ_inc_in;
         occ_dec_ff   <= occ_dec_in;
         ops_inc_ff   <= ops_inc_in;
         if (commit) begin
            occ_ff <= occ_in;
            ops_ff <= ops_in;
            if (wr_ff) valid_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      scan_ff        <= scan_in;
      self_free_ff   <= self_free_in;
      res_granted_ff <= res_granted_in;
      res_match_ff   <= res_match_in;
      res_status_ff  <= res_status_in;
      wr_addr_ff     <= wr_addr_in;
      if (commit) begin
         rsp_ff.granted_frame   <= res_granted_ff;
         rsp_ff.pair_matches    <= res_match_ff;
         rsp_ff.status          <= res_status_ff;
         rsp_ff.occupied_count  <= occ_wide[OCC_BITS-1:0];
         rsp_ff.operation_count <= ops_in;
      end
   end

   // Table write: full pair on allocate or reassign, owner only on release.
   always_ff @(posedge clock) begin
      if (commit && (wr_ff || clr_ff)) begin
         owner_mem[wr_addr_ff] <= clr_ff ? '0 : req_ff.owner_id;
      end
      if (commit && wr_ff) begin
         page_mem[wr_addr_ff] <= req_ff.page_number;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (rd_issue) begin
         rd_owner_ff <= owner_mem[rd_addr];
         rd_page_ff  <= page_mem[rd_addr];
         rd_ok_ff    <= valid_ff[rd_addr];
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FRAME_COUNT)
      else $error("occupied count above frame count");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= FRAME_COUNT))
      else $error("scan pointer ran past the table");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("response beat raised outside completion");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.granted_frame == '0) || (rsp_ff.status == STAT_OK)))
      else $error("frame granted with error status");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !(wr_ff && clr_ff))
      else $error("write and release pending together");

endmodule

// ===== tb/sv/tb_frame_table_allocator.sv =====
`timescale 1ns / 1ps

module tb_frame_table_allocator;
   import fta_pkg::*;

   localparam int FRAMES     = FRAME_COUNT_DEF;
   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD  = 400;
   localparam int MAX_LOGGED = 100;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fta_req_type req       = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fta_rsp_type rsp;

   // shadow copy of the frame table
   logic [OWNER_BITS-1:0] frame_owner [FRAMES];
   logic [PAGE_BITS-1:0]  frame_page  [FRAMES];
   logic [OCC_BITS-1:0]   occupied_now;
   logic [OPS_BITS-1:0]   ops_now;

   fta_rsp_type table_replies_due [$];

   int mismatch_count = 0;
   int requests_taken = 0;
   int status_seen [8];
   int matches_seen   = 0;
   int idle_cycles    = 0;

   // sender burst state
   int burst_left = 0;

   // receiver long hold-off, requested by the test and counted by the receiver
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int seg_left      = 0;
   int seg_mode      = 0;
   int run_left      = 0;
   bit run_stalled   = 1'b0;
   int pattern_phase = 0;

   logic [OWNER_BITS-1:0] owner_pool [8];
   logic [PAGE_BITS-1:0]  page_pool  [8];

   frame_table_allocator #(
      .FRAME_COUNT(FRAMES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         frame_owner[i] = '0;
         frame_page[i]  = '0;
      end
      occupied_now = '0;
      ops_now      = '0;
      for (int i = 0; i < 8; i++) begin
         status_seen[i] = 0;
      end
   end

   function automatic fta_rsp_type apply_frame_request(fta_req_type r);
      fta_rsp_type res;
      int          idx;
      bit          hit;
      res        = '0;
      res.status = STAT_OK;
      idx        = int'(r.frame_number);
      hit        = 1'b0;
      if (r.req_type == REQ_ALLOC) begin
         res.status = STAT_FULL;
         for (int i = 0; i < FRAMES && !hit; i++) begin
            if (frame_owner[i] == '0) begin
               frame_owner[i] = r.owner_id;
               frame_page[i]  = r.page_number;
               if (occupied_now < FRAMES) occupied_now = occupied_now + 1'b1;
               ops_now           = ops_now + 1'b1;
               res.granted_frame = i[FRAME_BITS-1:0];
               res.status        = STAT_OK;
               hit               = 1'b1;
            end
         end
      end else if (idx >= FRAMES) begin
         res.status = STAT_BAD_FRAME;
      end else if (r.req_type == REQ_RELEASE) begin
         if (occupied_now == '0) begin
            res.status = STAT_NONE_OCC;
         end else begin
            // a free frame is released again and still counts down
            frame_owner[idx] = '0;
            occupied_now     = occupied_now - 1'b1;
         end
      end else if (r.req_type == REQ_REASSIGN) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (i != idx && frame_owner[i] == r.owner_id && frame_page[i] == r.page_number)
               res.status = STAT_DUPLICATE;
         end
         if (res.status == STAT_OK && frame_owner[idx] == '0) res.status = STAT_NOT_ALLOC;
         if (res.status == STAT_OK) begin
            frame_owner[idx]  = r.owner_id;
            frame_page[idx]   = r.page_number;
            ops_now           = ops_now + 1'b1;
            res.granted_frame = idx[FRAME_BITS-1:0];
         end
      end else begin
         res.pair_matches = (frame_owner[idx] == r.owner_id) &&
                            (frame_page[idx] == r.page_number);
      end
      res.occupied_count  = occupied_now;
      res.operation_count = ops_now;
      return res;
   endfunction

   function automatic int pick_held_frame();
      int start;
      int idx;
      start = $urandom_range(0, FRAMES - 1);
      for (int k = 0; k < FRAMES; k++) begin
         idx = (start + k) % FRAMES;
         if (frame_owner[idx] != '0) return idx;
      end
      return -1;
   endfunction

   function automatic int free_frames();
      int n;
      n = 0;
      for (int i = 0; i < FRAMES; i++) begin
         if (frame_owner[i] == '0) n++;
      end
      return n;
   endfunction

   function automatic logic [OWNER_BITS-1:0] pick_owner();
      if ($urandom_range(0, 9) < 7) return owner_pool[$urandom_range(0, 7)];
      return OWNER_BITS'($urandom_range(0, 65535));
   endfunction

   function automatic logic [PAGE_BITS-1:0] pick_page();
      if ($urandom_range(0, 9) < 7) return page_pool[$urandom_range(0, 7)];
      return PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
   endfunction

   // score accepted beats on both channels
   always @(posedge clock) begin : score
      fta_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = apply_frame_request(req);
            table_replies_due.push_back(want);
            requests_taken++;
            status_seen[want.status]++;
            if (want.pair_matches) matches_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (table_replies_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_LOGGED)
                  $display("%0t: unexpected beat: frame=%0d match=%0b st=%0d occ=%0d ops=%0d",
                           $time, rsp.granted_frame, rsp.pair_matches, rsp.status,
                           rsp.occupied_count, rsp.operation_count);
            end else begin
               want = table_replies_due.pop_front();
               if (rsp.granted_frame !== want.granted_frame ||
                   rsp.pair_matches !== want.pair_matches ||
                   rsp.status !== want.status ||
                   rsp.occupied_count !== want.occupied_count ||
                   rsp.operation_count !== want.operation_count) begin
                  mismatch_count++;
                  // cap the log on a badly broken block
                  if (mismatch_count <= MAX_LOGGED) begin
                     $display("%0t: mismatch expected frame=%0d match=%0b st=%0d occ=%0d ops=%0d",
                              $time, want.granted_frame, want.pair_matches, want.status,
                              want.occupied_count, want.operation_count);
                     $display("%0t:          actual frame=%0d match=%0b st=%0d occ=%0d ops=%0d",
                              $time, rsp.granted_frame, rsp.pair_matches, rsp.status,
                              rsp.occupied_count, rsp.operation_count);
                  end
               end
            end
         end
      end
   end

   // receiver: a long hold when asked, else segments of different stall patterns
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 300);
         end
         seg_left--;
         pattern_phase++;
         case (seg_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            2: begin
               rsp_stall <= (pattern_phase % 5) < 2;
            end
            default: begin
               if (run_left == 0) begin
                  run_left    = $urandom_range(1, 8);
                  run_stalled = !run_stalled;
               end
               run_left--;
               rsp_stall <= run_stalled;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_request(logic [1:0] kind, logic [OWNER_BITS-1:0] owner,
                               logic [PAGE_BITS-1:0] page, logic [FRAME_BITS-1:0] frame);
      fta_req_type item;
      int          gap;
      item.req_type     = kind;
      item.owner_id     = owner;
      item.page_number  = page;
      item.frame_number = frame;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req       <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (table_replies_due.size() != 0);
   endtask

   task automatic test_empty_table_corners();
      send_request(REQ_RELEASE, 16'h0001, 20'h00001, 8'd5);       // nothing counted
      send_request(REQ_RELEASE, 16'hFFFF, 20'hFFFFF, 8'd255);     // range test comes first
      send_request(REQ_CHECK, 16'h0000, 20'h00000, 8'd63);        // cleared frame matches 0/0
      send_request(REQ_REASSIGN, 16'h0000, 20'h00000, 8'd0);      // free frames hold 0/0
      send_request(REQ_REASSIGN, 16'h0005, 20'h00007, 8'd0);      // free frame
      drain_replies();
   endtask

   task automatic test_first_fit_and_owner_zero();
      send_request(REQ_ALLOC, 16'hFFFF, 20'hFFFFF, 8'hFF);
      send_request(REQ_ALLOC, 16'h0000, 20'h00000, 8'h00);        // stored yet still free
      send_request(REQ_ALLOC, 16'h0001, 20'h00001, 8'h00);        // lands on the same frame
      send_request(REQ_ALLOC, 16'hAAAA, 20'h55555, 8'hAA);
      send_request(REQ_CHECK, 16'hFFFF, 20'hFFFFF, 8'd0);
      send_request(REQ_CHECK, 16'hFFFE, 20'hFFFFF, 8'd0);
      send_request(REQ_CHECK, 16'hFFFF, 20'hFFFFF, 8'd64);
      drain_replies();
   endtask

   task automatic test_reassign_and_release();
      send_request(REQ_REASSIGN, 16'hFFFF, 20'hFFFFF, 8'd1);      // duplicate of frame 0
      send_request(REQ_REASSIGN, 16'hFFFF, 20'hFFFFF, 8'd0);      // own pair is no duplicate
      send_request(REQ_REASSIGN, 16'h5555, 20'hAAAAA, 8'd2);
      send_request(REQ_REASSIGN, 16'h1234, 20'h12345, 8'd200);
      send_request(REQ_REASSIGN, 16'h1234, 20'h12345, 8'd10);
      send_request(REQ_RELEASE, 16'h0000, 20'h00000, 8'd20);      // free frame still counts down
      send_request(REQ_RELEASE, 16'h0000, 20'h00000, 8'd2);
      send_request(REQ_CHECK, 16'h5555, 20'hAAAAA, 8'd2);
      send_request(REQ_RELEASE, 16'h0000, 20'h00000, 8'd128);
      drain_replies();
   endtask

   task automatic test_fill_until_full();
      int n;
      n = 0;
      while (free_frames() > 0) begin
         // owner zero now and then pushes the count to saturation
         if (n % 8 == 7) begin
            send_request(REQ_ALLOC, '0, PAGE_BITS'($urandom_range(0, 1023)),
                         FRAME_BITS'($urandom_range(0, 255)));
         end else begin
            send_request(REQ_ALLOC, OWNER_BITS'($urandom_range(1, 65535)),
                         PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1)),
                         FRAME_BITS'($urandom_range(0, 255)));
         end
         n++;
         // the sender may run ahead of scoring by one beat
         if (free_frames() == 1) drain_replies();
      end
      send_request(REQ_ALLOC, 16'hFFFF, 20'hFFFFF, 8'd0);
      send_request(REQ_ALLOC, 16'h0000, 20'h00000, 8'd0);
      send_request(REQ_REASSIGN, frame_owner[5], frame_page[5], 8'd6);
      send_request(REQ_REASSIGN, 16'hBEEF, 20'h0BEEF, 8'd63);
      drain_replies();
   endtask

   task automatic test_long_hold();
      int f;
      hold_requests++;
      for (int k = 0; k < 30; k++) begin
         f = $urandom_range(0, FRAMES - 1);
         if (k % 3 == 0) send_request(REQ_ALLOC, pick_owner(), pick_page(), 8'd0);
         else send_request(REQ_CHECK, frame_owner[f], frame_page[f], f[7:0]);
      end
      drain_replies();
   endtask

   task automatic test_random_mix(int total);
      int                    sent;
      int                    sess_left;
      int                    w_alloc, w_rel, w_reas;
      int                    roll, held, other;
      logic [1:0]            kind;
      logic [OWNER_BITS-1:0] owner;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
      sent      = 0;
      sess_left = 0;
      w_alloc   = 30;
      w_rel     = 25;
      w_reas    = 20;
      while (sent < total) begin
         if (sess_left == 0) begin
            case ($urandom_range(0, 2))
               0: begin w_alloc = 60; w_rel = 10; w_reas = 15; end
               1: begin w_alloc = 10; w_rel = 60; w_reas = 15; end
               default: begin w_alloc = 30; w_rel = 25; w_reas = 20; end
            endcase
            sess_left = $urandom_range(40, 150);
            if ($urandom_range(0, 4) == 0) drain_replies();
         end
         sess_left--;
         owner = pick_owner();
         page  = pick_page();
         frame = FRAME_BITS'($urandom_range(0, 255));
         roll  = $urandom_range(0, 99);
         if (roll < 8) begin
            kind  = 2'($urandom_range(0, 3));
            owner = OWNER_BITS'($urandom_range(0, 65535));
            page  = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < w_alloc) kind = REQ_ALLOC;
            else if (roll < w_alloc + w_rel) kind = REQ_RELEASE;
            else if (roll < w_alloc + w_rel + w_reas) kind = REQ_REASSIGN;
            else kind = REQ_CHECK;
            if (kind != REQ_ALLOC) begin
               held = pick_held_frame();
               roll = $urandom_range(0, 99);
               if (held >= 0 && roll < 75) frame = FRAME_BITS'(held);
               else if (roll < 90) frame = FRAME_BITS'($urandom_range(0, FRAMES - 1));
            end
            roll = $urandom_range(0, 99);
            if (kind == REQ_REASSIGN) begin
               other = pick_held_frame();
               if (other >= 0 && roll < 35) begin
                  owner = frame_owner[other];
                  page  = frame_page[other];
               end else if (frame < FRAMES && roll < 50) begin
                  owner = frame_owner[frame];
                  page  = frame_page[frame];
               end
            end else if (kind == REQ_CHECK && frame < FRAMES) begin
               if (roll < 50) begin
                  owner = frame_owner[frame];
                  page  = frame_page[frame];
               end else if (roll < 60) begin
                  owner = frame_owner[frame] ^ (16'd1 << $urandom_range(0, OWNER_BITS - 1));
                  page  = frame_page[frame];
               end else if (roll < 70) begin
                  owner = frame_owner[frame];
                  page  = frame_page[frame] ^ (20'd1 << $urandom_range(0, PAGE_BITS - 1));
               end
            end
         end
         send_request(kind, owner, page, frame);
         sent++;
      end
      drain_replies();
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         owner_pool[i] = OWNER_BITS'($urandom_range(1, 65535));
         page_pool[i]  = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
      end
      owner_pool[0] = '0;
      page_pool[0]  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table_corners();
      test_first_fit_and_owner_zero();
      test_reassign_and_release();
      test_fill_until_full();
      test_long_hold();
      test_random_mix(1180);
      drain_replies();
      repeat (2 * (FRAMES + 3)) @(posedge clock);
      $display("covered %0d requests: %0d ok, %0d table full, %0d bad frame, %0d none occupied",
               requests_taken, status_seen[STAT_OK], status_seen[STAT_FULL],
               status_seen[STAT_BAD_FRAME], status_seen[STAT_NONE_OCC]);
      $display("  %0d duplicate pair, %0d not allocated, %0d matching checks, long hold-off",
               status_seen[STAT_DUPLICATE], status_seen[STAT_NOT_ALLOC], matches_seen);
      if (mismatch_count == 0 && table_replies_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
